// File: rtl/msk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msk_pkg;

  // Stack geometry
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

  // Field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned STATUS_W = 2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_MAX = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // What a cell does in one cycle
  typedef enum logic [1:0] {
    MODE_RELAX,
    MODE_SHALLOW,
    MODE_DEEP
  } cell_mode_t;

  // One cell: its entry, the largest entry from here down to the bottom,
  // and the distance from this cell to the cell holding that largest entry
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] smax;
    logic [IDX_W-1:0] off;
  } cell_rec_t;

  typedef struct packed {
    cell_mode_t mode;
    logic deep_valid;
  } cell_ctl_t;

  // Merge an entry with the summary of the cells below it; the newer entry
  // wins a tie
  function automatic cell_rec_t settle_rec(logic signed [DATA_W-1:0] val,
                                           cell_rec_t deep, logic deep_valid);
    cell_rec_t res;
    res.val = val;
    if (!deep_valid || (val >= deep.smax)) begin
      res.smax = val;
      res.off = '0;
    end else begin
      res.smax = deep.smax;
      res.off = deep.off + IDX_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/max_stack.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded stack of signed 32-bit values that reports its maximum after every
// command. The stack lives in a row of cells with the top entry in cell 0;
// each cell also carries the largest entry from itself down to the bottom.
// Each command passes through a settle state, then its result is registered
// onto the output; no new command is taken before that. Pop maximum stays
// longer in the settle state: the running maximum has to ripple back up
// through the cells of the entries pushed after the removed maximum, one
// cell per clock. A new command is taken while a result still waits on
// the output; the input then stalls until that result is taken. Entry
// storage needs no clearing after reset.
module max_stack (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [msk_pkg::CMD_W-1:0]            in_command,
  input  wire logic signed [msk_pkg::DATA_W-1:0]    in_push_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [msk_pkg::DATA_W-1:0]         out_removed_value,
  output logic signed [msk_pkg::DATA_W-1:0]         out_top_value,
  output logic signed [msk_pkg::DATA_W-1:0]         out_max_value,
  output logic [msk_pkg::COUNT_OUT_W-1:0]           out_entry_count,
  output logic                                      out_is_empty,
  output logic [msk_pkg::STATUS_W-1:0]              out_status
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SETTLE = 1'b1;

  msk_pkg::cell_rec_t rec [msk_pkg::STACK_DEPTH];
  msk_pkg::cell_ctl_t ctl [msk_pkg::STACK_DEPTH];
  msk_pkg::cell_rec_t push_rec;

  logic state_r, state_nxt;
  logic [msk_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [msk_pkg::IDX_W-1:0] settle_r, settle_nxt;
  logic signed [msk_pkg::DATA_W-1:0] removed_r, removed_nxt;
  logic [msk_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic out_valid_r, out_valid_nxt;
  logic signed [msk_pkg::DATA_W-1:0] out_removed_r, out_top_r, out_max_r;
  logic [msk_pkg::COUNT_OUT_W-1:0] out_count_r;
  logic out_empty_r;
  logic [msk_pkg::STATUS_W-1:0] out_status_r;

  logic accept, emit, is_empty_now;
  logic do_push, do_pop, do_pop_max;
  logic [msk_pkg::IDX_W-1:0] max_pos;

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign is_empty_now = (count_r == '0);
  assign max_pos = rec[0].off;

  // Decode the accepted command
  always_comb begin
    do_push = 1'b0;
    do_pop = 1'b0;
    do_pop_max = 1'b0;
    status_nxt = status_r;
    removed_nxt = removed_r;
    if (accept) begin
      status_nxt = msk_pkg::ST_OK;
      removed_nxt = '0;
      unique case (in_command)
        msk_pkg::CMD_PUSH: begin
          if (count_r == msk_pkg::FULL_COUNT) status_nxt = msk_pkg::ST_FULL;
          else do_push = 1'b1;
        end
        msk_pkg::CMD_POP: begin
          if (is_empty_now) status_nxt = msk_pkg::ST_EMPTY;
          else begin
            do_pop = 1'b1;
            removed_nxt = rec[0].val;
          end
        end
        msk_pkg::CMD_POP_MAX: begin
          if (is_empty_now) status_nxt = msk_pkg::ST_EMPTY;
          else begin
            do_pop_max = 1'b1;
            removed_nxt = rec[0].smax;
          end
        end
        default: ;
      endcase
    end
  end

  // New top record for a push
  assign push_rec = msk_pkg::settle_rec(in_push_value, rec[0], !is_empty_now);

  // Cell chain
  for (genvar i = 0; i < msk_pkg::STACK_DEPTH; i++) begin : g_cell
    localparam logic [msk_pkg::CNT_W-1:0] NEXT_CNT = msk_pkg::CNT_W'(i + 1);
    localparam logic [msk_pkg::IDX_W-1:0] POS = msk_pkg::IDX_W'(i);
    msk_pkg::cell_rec_t shallow_in, deep_in;

    if (i == 0) begin : g_top
      assign shallow_in = push_rec;
    end else begin : g_mid
      assign shallow_in = rec[i-1];
    end
    if (i == msk_pkg::STACK_DEPTH - 1) begin : g_bottom
      assign deep_in = '0;
    end else begin : g_inner
      assign deep_in = rec[i+1];
    end

    // Select the cell's action for this cycle
    always_comb begin
      ctl[i].deep_valid = (NEXT_CNT < count_r);
      if (do_push) ctl[i].mode = msk_pkg::MODE_SHALLOW;
      else if (do_pop || (do_pop_max && (POS >= max_pos)))
        ctl[i].mode = msk_pkg::MODE_DEEP;
      else ctl[i].mode = msk_pkg::MODE_RELAX;
    end

    msk_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[i]),
      .shallow_rec (shallow_in),
      .deep_rec    (deep_in),
      .rec         (rec[i])
    );
  end

  // Sequence one command and wait for the running maximum to settle
  assign emit = (state_r == S_SETTLE) && (settle_r == '0) &&
                (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    settle_nxt = settle_r;
    count_nxt = count_r;
    if (do_push) count_nxt = count_r + msk_pkg::CNT_W'(1);
    else if (do_pop || do_pop_max) count_nxt = count_r - msk_pkg::CNT_W'(1);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SETTLE;
          settle_nxt = do_pop_max ? max_pos : '0;
        end
      end
      S_SETTLE: begin
        if (settle_r != '0) settle_nxt = settle_r - msk_pkg::IDX_W'(1);
        else if (emit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold a result until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      settle_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      settle_r <= settle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    removed_r <= removed_nxt;
    status_r <= status_nxt;
    if (emit) begin
      out_removed_r <= removed_r;
      out_top_r <= is_empty_now ? '0 : rec[0].val;
      out_max_r <= is_empty_now ? '0 : rec[0].smax;
      out_count_r <= msk_pkg::COUNT_OUT_W'(count_r);
      out_empty_r <= is_empty_now;
      out_status_r <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_top_value = out_top_r;
  assign out_max_value = out_max_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty = out_empty_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// File: rtl/msk_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module msk_cell (
  input  wire logic                clk,
  input  wire msk_pkg::cell_ctl_t  ctl,
  input  wire msk_pkg::cell_rec_t  shallow_rec,
  input  wire msk_pkg::cell_rec_t  deep_rec,
  output msk_pkg::cell_rec_t       rec
);

  msk_pkg::cell_rec_t rec_r;
  msk_pkg::cell_rec_t rec_nxt;

  // Take a neighbor's record on a shift, else refresh the running maximum
  always_comb begin
    case (ctl.mode)
      msk_pkg::MODE_SHALLOW: rec_nxt = shallow_rec;
      msk_pkg::MODE_DEEP:    rec_nxt = deep_rec;
      default:               rec_nxt = msk_pkg::settle_rec(rec_r.val, deep_rec,
                                                           ctl.deep_valid);
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

`default_nettype wire

// File: rtl/msk_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module msk_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic signed [msk_pkg::DATA_W-1:0]    out_removed_value,
  input wire logic signed [msk_pkg::DATA_W-1:0]    out_top_value,
  input wire logic signed [msk_pkg::DATA_W-1:0]    out_max_value,
  input wire logic [msk_pkg::COUNT_OUT_W-1:0]      out_entry_count,
  input wire logic                                 out_is_empty,
  input wire logic [msk_pkg::STATUS_W-1:0]         out_status
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_removed_value) &&
    $stable(out_max_value) && $stable(out_top_value) && $stable(out_status))
    else $error("stalled result changed");

  // An empty stack reports zero top and maximum
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_top_value == '0 && out_max_value == '0)
    else $error("empty stack reports nonzero top or maximum");

  // A rejected command removes nothing
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != msk_pkg::ST_OK |-> out_removed_value == '0)
    else $error("rejected command reports a removed value");

  // The maximum is never below the top entry
  a_max_ge_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_empty |-> out_max_value >= out_top_value)
    else $error("maximum below top entry");

  // A push is refused only on a full stack
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == msk_pkg::ST_FULL |->
    out_entry_count == msk_pkg::COUNT_OUT_W'(msk_pkg::STACK_DEPTH) && !out_is_empty)
    else $error("full status with stack not full");

endmodule

bind max_stack msk_checker u_msk_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_removed_value (out_removed_value),
  .out_top_value     (out_top_value),
  .out_max_value     (out_max_value),
  .out_entry_count   (out_entry_count),
  .out_is_empty      (out_is_empty),
  .out_status        (out_status)
);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import msk_pkg::*;

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT = 50000;
  localparam int unsigned SETTLE_CYCLES = 100;

  // One stack report as the block presents it
  typedef struct packed {
    logic signed [DATA_W-1:0] removed;
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] maxv;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     is_empty;
    logic [STATUS_W-1:0]      status;
  } stack_report_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command = CMD_QUERY;
  logic signed [DATA_W-1:0] in_push_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_removed_value;
  logic signed [DATA_W-1:0] out_top_value;
  logic signed [DATA_W-1:0] out_max_value;
  logic [COUNT_OUT_W-1:0]   out_entry_count;
  logic                     out_is_empty;
  logic [STATUS_W-1:0]      out_status;

  // Shadow stack, bottom entry in cell 0
  logic signed [DATA_W-1:0] shadow_cells [STACK_DEPTH];
  int unsigned              shadow_fill = 0;
  stack_report_t            pending_reports [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_token = 1'b0;
  logic        hold_token_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;

  max_stack uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_push_value     (in_push_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_removed_value (out_removed_value),
    .out_top_value     (out_top_value),
    .out_max_value     (out_max_value),
    .out_entry_count   (out_entry_count),
    .out_is_empty      (out_is_empty),
    .out_status        (out_status)
  );

  always #10 clk = ~clk;

  // Position of the newest entry holding the largest value
  function automatic int unsigned newest_max_pos();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < shadow_fill; i++) begin
      if (shadow_cells[i] >= shadow_cells[best]) best = i;
    end
    return best;
  endfunction

  // Apply one command to the shadow stack and build the report it produces
  function automatic stack_report_t apply_command(logic [CMD_W-1:0] cmd,
                                                  logic signed [DATA_W-1:0] val);
    stack_report_t rep;
    int unsigned pos;
    rep = '0;
    rep.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          shadow_cells[shadow_fill] = val;
          shadow_fill++;
        end
      end
      CMD_POP, CMD_POP_MAX: begin
        if (shadow_fill == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          pos = (cmd == CMD_POP) ? shadow_fill - 1 : newest_max_pos();
          rep.removed = shadow_cells[pos];
          // close the gap, keeping order above the removed entry
          for (int unsigned i = pos; i + 1 < shadow_fill; i++) begin
            shadow_cells[i] = shadow_cells[i + 1];
          end
          shadow_fill--;
        end
      end
      default: ;
    endcase
    if (shadow_fill > 0) begin
      rep.top = shadow_cells[shadow_fill - 1];
      rep.maxv = shadow_cells[newest_max_pos()];
    end
    rep.count = COUNT_OUT_W'(shadow_fill);
    rep.is_empty = (shadow_fill == 0);
    return rep;
  endfunction

  // Mix of wide random values, a narrow band that makes ties, and extremes
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return $urandom;
    if (roll < 8) return $urandom_range(0, 16) - 8;
    case ($urandom_range(0, 3))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Offer one command and record its report once the block takes it
  task automatic issue_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_push_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reports.push_back(apply_command(cmd, val));
  endtask

  task automatic check_report();
    stack_report_t want;
    if (pending_reports.size() == 0) begin
      $error("report arrived with no command pending");
      fail_count++;
    end else begin
      want = pending_reports.pop_front();
      if (out_removed_value !== want.removed) begin
        $error("removed_value expected %0d got %0d", want.removed, out_removed_value);
        fail_count++;
      end
      if (out_top_value !== want.top) begin
        $error("top_value expected %0d got %0d", want.top, out_top_value);
        fail_count++;
      end
      if (out_max_value !== want.maxv) begin
        $error("max_value expected %0d got %0d", want.maxv, out_max_value);
        fail_count++;
      end
      if (out_entry_count !== want.count) begin
        $error("entry_count expected %0d got %0d", want.count, out_entry_count);
        fail_count++;
      end
      if (out_is_empty !== want.is_empty) begin
        $error("is_empty expected %0d got %0d", want.is_empty, out_is_empty);
        fail_count++;
      end
      if (out_status !== want.status) begin
        $error("status expected %0d got %0d", want.status, out_status);
        fail_count++;
      end
    end
  endtask

  // Drive the output stall and check every transaction that leaves the block
  always @(posedge clk) begin
    if (hold_token != hold_token_seen) begin
      hold_token_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
    if (rst_n && out_valid && !out_stall) check_report();
  end

  // Removals from empty, extreme values, ties for the maximum, gap closing
  task automatic test_corner_commands();
    issue_command(CMD_POP, pick_value());
    issue_command(CMD_POP_MAX, pick_value());
    issue_command(CMD_QUERY, pick_value());
    issue_command(CMD_PUSH, WORD_MIN);
    issue_command(CMD_PUSH, WORD_MAX);
    issue_command(CMD_PUSH, '0);
    issue_command(CMD_PUSH, '1);
    issue_command(CMD_PUSH, WORD_MAX);
    issue_command(CMD_PUSH, 32'sd5);
    issue_command(CMD_QUERY, '0);
    issue_command(CMD_POP_MAX, '0);
    issue_command(CMD_POP_MAX, '0);
    issue_command(CMD_POP, '0);
    issue_command(CMD_POP_MAX, '0);
    issue_command(CMD_POP, '0);
    issue_command(CMD_QUERY, '1);
    issue_command(CMD_POP, '0);
    issue_command(CMD_POP, '0);
    issue_command(CMD_POP_MAX, '0);
    issue_command(CMD_PUSH, '1);
    issue_command(CMD_PUSH, '1);
    issue_command(CMD_POP_MAX, '0);
    issue_command(CMD_POP, '0);
  endtask

  // Fill to capacity, push onto the full stack, then drain mostly by pop maximum
  task automatic test_fill_and_drain();
    while (shadow_fill < STACK_DEPTH) issue_command(CMD_PUSH, pick_value());
    repeat (4) issue_command(CMD_PUSH, pick_value());
    issue_command(CMD_QUERY, pick_value());
    while (shadow_fill > 0) begin
      issue_command(($urandom_range(0, 99) < 70) ? CMD_POP_MAX : CMD_POP, pick_value());
    end
    issue_command(CMD_POP_MAX, pick_value());
  endtask

  // Hold the output for a long stretch while commands keep coming
  task automatic test_output_hold();
    int unsigned saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    hold_token <= ~hold_token;
    repeat (30) issue_command(CMD_PUSH, pick_value());
    repeat (30) issue_command(CMD_POP_MAX, pick_value());
    send_idle_pct = saved_pct;
  endtask

  // Random walk in bursts that grow, shrink or hover around a depth
  task automatic test_random_walk(input int unsigned n_items);
    int unsigned burst_left;
    int unsigned bias;
    int unsigned roll;
    logic [CMD_W-1:0] cmd;
    burst_left = 0;
    bias = 0;
    repeat (n_items) begin
      if (burst_left == 0) begin
        bias = $urandom_range(0, 2);
        burst_left = $urandom_range(10, 80);
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      case (bias)
        0: cmd = (roll < 70) ? CMD_PUSH : (roll < 80) ? CMD_POP :
                 (roll < 95) ? CMD_POP_MAX : CMD_QUERY;
        1: cmd = (roll < 20) ? CMD_PUSH : (roll < 55) ? CMD_POP :
                 (roll < 92) ? CMD_POP_MAX : CMD_QUERY;
        default: cmd = (roll < 45) ? CMD_PUSH : (roll < 70) ? CMD_POP :
                       (roll < 92) ? CMD_POP_MAX : CMD_QUERY;
      endcase
      issue_command(cmd, pick_value());
    end
  endtask

  initial begin
    int unsigned drain_cycles;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 74;
    test_corner_commands();
    test_fill_and_drain();
    test_random_walk(560);

    send_idle_pct = 74;
    recv_idle_pct = 19;
    test_output_hold();
    test_random_walk(560);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_walk(560);

    // drop valid and let outstanding reports come back
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (pending_reports.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("[max_stack] OK");
    end else begin
      $display("[max_stack] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20_000_000;
    $display("[max_stack] ERROR");
    $finish;
  end

endmodule
